FILE: sv/pcorr_pkg.sv
package pcorr_pkg;

  // Set capacity and sample width.
  localparam int MAX_PAIRS   = 1024;
  localparam int SAMPLE_BITS = 16;

  // Fixed port widths.
  localparam int IN_W      = 16;
  localparam int CORR_W    = 16;
  localparam int STAT_W    = 2;
  localparam int OUT_CNT_W = 11;

  // Accumulator widths.
  localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int S_W    = SAMPLE_BITS + CNT_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W - 2;
  localparam int XY_W   = SQ_W + 1;

  // Back end widths: variances, numerator magnitude, search words.
  localparam int VW           = CNT_W + SQ_W;
  localparam int MW           = VW + 1;
  localparam int DW           = 2 * VW;
  localparam int SEARCH_SHIFT = 30;
  localparam int SW           = 2 * MW + SEARCH_SHIFT + 2;
  localparam int Q_W          = CORR_W;
  localparam int K_W          = $clog2(Q_W);
  localparam logic [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W - 1){1'b1}}};

  // Iterative multiplier: operands split into two halves each.
  localparam int MUL_HW    = (MW + 1) / 2;
  localparam int MUL_OW    = 2 * MUL_HW;
  localparam int MUL_PW    = 2 * MUL_OW;
  localparam int MUL_PARTS = 4;
  localparam int IDX_W     = $clog2(MUL_PARTS + 1);

  // Queue of finished sets between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int LVL_W  = $clog2(QDEPTH + 1);

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO_VAR = 2'd1;
  localparam logic [STAT_W-1:0] STAT_CAPACITY = 2'd2;

  // Accumulated totals of one set.
  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [S_W-1:0]   sum_x;
    logic signed [S_W-1:0]   sum_y;
    logic [SQ_W-1:0]         sum_xx;
    logic [SQ_W-1:0]         sum_yy;
    logic signed [XY_W-1:0]  sum_xy;
    logic                    overflow;
  } snap_t;

  // Multiplier request and response.
  typedef struct packed {
    logic              start;
    logic [MUL_OW-1:0] a;
    logic [MUL_OW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MUL_PW-1:0] prod;
  } mul_rsp_t;

endpackage

FILE: sv/pcorr_front.sv
module pcorr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pcorr_pkg::IN_W-1:0]   in_sample_x,
  input  logic signed [pcorr_pkg::IN_W-1:0]   in_sample_y,
  input  logic                                in_last_pair,
  input  logic [pcorr_pkg::LVL_W-1:0]         q_level,
  output logic                                push,
  output pcorr_pkg::snap_t                    push_data
);
  import pcorr_pkg::*;

  logic                          in_accept;
  logic signed [SAMPLE_BITS-1:0] xs;
  logic signed [SAMPLE_BITS-1:0] ys;
  logic signed [PROD_W-1:0]      xx_p;
  logic signed [PROD_W-1:0]      yy_p;
  logic signed [PROD_W-1:0]      xy_p;

  logic                          s1_valid_r;
  logic                          s1_last_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic [PROD_W-1:0]             xx_r;
  logic [PROD_W-1:0]             yy_r;
  logic signed [PROD_W-1:0]      xy_r;

  snap_t                         acc_r;
  snap_t                         acc_nxt;
  logic                          pending;
  logic [LVL_W:0]                occ;

  // The queue must have room for every set whose last word is still in flight.
  assign pending   = s1_valid_r && s1_last_r;
  assign occ       = {1'b0, q_level} + (LVL_W + 1)'(pending);
  assign in_stall  = occ >= (LVL_W + 1)'(QDEPTH);
  assign in_accept = in_valid && !in_stall;

  // Samples are taken at the configured width and sign extended.
  assign xs   = in_sample_x[SAMPLE_BITS-1:0];
  assign ys   = in_sample_y[SAMPLE_BITS-1:0];
  assign xx_p = PROD_W'(xs) * PROD_W'(xs);
  assign yy_p = PROD_W'(ys) * PROD_W'(ys);
  assign xy_p = PROD_W'(xs) * PROD_W'(ys);

  // First stage: register the products of the accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_last_r <= in_last_pair;
      x_r       <= xs;
      y_r       <= ys;
      xx_r      <= xx_p;
      yy_r      <= yy_p;
      xy_r      <= xy_p;
    end
  end

  // Second stage: accumulate unless the set is already full.
  always_comb begin
    acc_nxt = acc_r;
    if (s1_valid_r) begin
      if (acc_r.count < CNT_W'(MAX_PAIRS)) begin
        acc_nxt.count  = acc_r.count + CNT_W'(1);
        acc_nxt.sum_x  = acc_r.sum_x + S_W'(x_r);
        acc_nxt.sum_y  = acc_r.sum_y + S_W'(y_r);
        acc_nxt.sum_xx = acc_r.sum_xx + SQ_W'(xx_r);
        acc_nxt.sum_yy = acc_r.sum_yy + SQ_W'(yy_r);
        acc_nxt.sum_xy = acc_r.sum_xy + XY_W'(xy_r);
      end else begin
        acc_nxt.overflow = 1'b1;
      end
    end
  end

  // The last word of a set hands the totals on and clears the accumulators.
  assign push      = pending;
  assign push_data = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (push) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

FILE: sv/pcorr_queue.sv
module pcorr_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  pcorr_pkg::snap_t            push_data,
  input  logic                        pop,
  output pcorr_pkg::snap_t            head,
  output logic [pcorr_pkg::LVL_W-1:0] level
);
  import pcorr_pkg::*;

  snap_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [LVL_W-1:0]   level_r;

  assign head  = mem_r[rd_ptr_r];
  assign level = level_r;

  // Pointer and fill level bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        level_r <= level_r + LVL_W'(1);
      end else if (pop && !push) begin
        level_r <= level_r - LVL_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/pcorr_mul.sv
module pcorr_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcorr_pkg::mul_req_t   req,
  output pcorr_pkg::mul_rsp_t   rsp
);
  import pcorr_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [IDX_W-1:0]      idx_r;
  logic [MUL_OW-1:0]     a_r;
  logic [MUL_OW-1:0]     b_r;
  logic [2*MUL_HW-1:0]   pp_r;
  logic [1:0]            sh_r;
  logic [MUL_PW-1:0]     acc_r;

  logic [MUL_HW-1:0]     a_half;
  logic [MUL_HW-1:0]     b_half;
  logic [MUL_PW-1:0]     pp_placed;
  logic                  last_step;

  // Bit 0 of the step picks the half of a, bit 1 the half of b.
  assign a_half    = idx_r[0] ? a_r[MUL_OW-1:MUL_HW] : a_r[MUL_HW-1:0];
  assign b_half    = idx_r[1] ? b_r[MUL_OW-1:MUL_HW] : b_r[MUL_HW-1:0];
  assign last_step = idx_r == IDX_W'(MUL_PARTS);

  // Place the registered partial product at its weight.
  always_comb begin
    case (sh_r)
      2'd0:    pp_placed = MUL_PW'(pp_r);
      2'd1:    pp_placed = MUL_PW'(pp_r) << MUL_HW;
      default: pp_placed = MUL_PW'(pp_r) << (2 * MUL_HW);
    endcase
  end

  // Control: busy from the start until every partial product is formed and summed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= busy_r && last_step;
      if (req.start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= idx_r + IDX_W'(1);
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: one half by half product per cycle, summed into the total in the cycle after.
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (!last_step) begin
        pp_r <= a_half * b_half;
        sh_r <= {1'b0, idx_r[0]} + {1'b0, idx_r[1]};
      end
      if (idx_r != '0) begin
        acc_r <= acc_r + pp_placed;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

FILE: sv/pcorr_back.sv
module pcorr_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [pcorr_pkg::LVL_W-1:0]          q_level,
  input  pcorr_pkg::snap_t                     q_head,
  output logic                                 q_pop,
  output pcorr_pkg::mul_req_t                  mul_req,
  input  pcorr_pkg::mul_rsp_t                  mul_rsp,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pcorr_pkg::CORR_W-1:0]  out_correlation,
  output logic [pcorr_pkg::STAT_W-1:0]         out_status,
  output logic [pcorr_pkg::OUT_CNT_W-1:0]      out_pair_count
);
  import pcorr_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL_GO   = 3'd1;
  localparam logic [2:0] ST_MUL_WAIT = 3'd2;
  localparam logic [2:0] ST_DELTA    = 3'd3;
  localparam logic [2:0] ST_TEST     = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  // Multiply steps, in order.
  localparam logic [2:0] OP_N_SXX  = 3'd0;
  localparam logic [2:0] OP_SX_SQ  = 3'd1;
  localparam logic [2:0] OP_N_SYY  = 3'd2;
  localparam logic [2:0] OP_SY_SQ  = 3'd3;
  localparam logic [2:0] OP_N_SXY  = 3'd4;
  localparam logic [2:0] OP_SX_SY  = 3'd5;
  localparam logic [2:0] OP_VX_VY  = 3'd6;
  localparam logic [2:0] OP_MAG_SQ = 3'd7;

  logic [2:0]             state_r, state_nxt;
  logic [2:0]             op_r, op_nxt;
  snap_t                  job_r, job_nxt;
  logic [VW-1:0]          ta_r, ta_nxt;
  logic [VW-1:0]          vx_r, vx_nxt;
  logic [VW-1:0]          vy_r, vy_nxt;
  logic [MW-1:0]          mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic                   zvar_r, zvar_nxt;
  logic [SW-1:0]          e_r, e_nxt;
  logic [SW-1:0]          dq_r, dq_nxt;
  logic [SW-1:0]          d2_r, d2_nxt;
  logic [SW-1:0]          delta_r, delta_nxt;
  logic [Q_W-1:0]         q_r, q_nxt;
  logic [K_W-1:0]         k_r, k_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CORR_W-1:0]      corr_r, corr_nxt;
  logic [STAT_W-1:0]      status_r, status_nxt;
  logic [OUT_CNT_W-1:0]   pcount_r, pcount_nxt;

  logic [S_W-1:0]         abs_sx;
  logic [S_W-1:0]         abs_sy;
  logic [XY_W-1:0]        abs_sxy;
  logic [VW-1:0]          prod_lo;
  logic                   sa;
  logic                   sb;
  logic [SW:0]            diff;
  logic [SW:0]            dq_sum;
  logic                   take;

  // Magnitudes of the signed sums.
  assign abs_sx  = job_r.sum_x[S_W-1] ? (~job_r.sum_x + S_W'(1)) : job_r.sum_x;
  assign abs_sy  = job_r.sum_y[S_W-1] ? (~job_r.sum_y + S_W'(1)) : job_r.sum_y;
  assign abs_sxy = job_r.sum_xy[XY_W-1] ? (~job_r.sum_xy + XY_W'(1)) : job_r.sum_xy;
  assign sa      = job_r.sum_xy[XY_W-1];
  assign sb      = job_r.sum_x[S_W-1] ^ job_r.sum_y[S_W-1];
  assign prod_lo = mul_rsp.prod[VW-1:0];

  // Operand selection for the current multiply step.
  always_comb begin
    mul_req.start = state_r == ST_MUL_GO;
    case (op_r)
      OP_N_SXX: begin
        mul_req.a = MUL_OW'(job_r.count);
        mul_req.b = MUL_OW'(job_r.sum_xx);
      end
      OP_SX_SQ: begin
        mul_req.a = MUL_OW'(abs_sx);
        mul_req.b = MUL_OW'(abs_sx);
      end
      OP_N_SYY: begin
        mul_req.a = MUL_OW'(job_r.count);
        mul_req.b = MUL_OW'(job_r.sum_yy);
      end
      OP_SY_SQ: begin
        mul_req.a = MUL_OW'(abs_sy);
        mul_req.b = MUL_OW'(abs_sy);
      end
      OP_N_SXY: begin
        mul_req.a = MUL_OW'(job_r.count);
        mul_req.b = MUL_OW'(abs_sxy);
      end
      OP_SX_SY: begin
        mul_req.a = MUL_OW'(abs_sx);
        mul_req.b = MUL_OW'(abs_sy);
      end
      OP_VX_VY: begin
        mul_req.a = MUL_OW'(vx_r);
        mul_req.b = MUL_OW'(vy_r);
      end
      default: begin
        mul_req.a = MUL_OW'(mag_r);
        mul_req.b = MUL_OW'(mag_r);
      end
    endcase
  end

  // One search step: remainder minus the growth of q squared times the denominator.
  assign diff   = {1'b0, e_r} - {1'b0, delta_r};
  assign dq_sum = {1'b0, delta_r} + {1'b0, d2_r};
  assign take   = !diff[SW] && !q_r[Q_W-1];

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    job_nxt       = job_r;
    ta_nxt        = ta_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    zvar_nxt      = zvar_r;
    e_nxt         = e_r;
    dq_nxt        = dq_r;
    d2_nxt        = d2_r;
    delta_nxt     = delta_r;
    q_nxt         = q_r;
    k_nxt         = k_r;
    corr_nxt      = corr_r;
    status_nxt    = status_r;
    pcount_nxt    = pcount_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_level != '0) begin
          q_pop     = 1'b1;
          job_nxt   = q_head;
          op_nxt    = OP_N_SXX;
          zvar_nxt  = 1'b0;
          state_nxt = ST_MUL_GO;
        end
      end

      ST_MUL_GO: begin
        state_nxt = ST_MUL_WAIT;
      end

      ST_MUL_WAIT: begin
        if (mul_rsp.done) begin
          op_nxt    = op_r + 3'd1;
          state_nxt = ST_MUL_GO;
          case (op_r)
            OP_N_SXX, OP_N_SYY, OP_N_SXY: begin
              ta_nxt = prod_lo;
            end
            OP_SX_SQ: begin
              vx_nxt = (ta_r >= prod_lo) ? ta_r - prod_lo : '0;
            end
            OP_SY_SQ: begin
              vy_nxt = (ta_r >= prod_lo) ? ta_r - prod_lo : '0;
            end
            OP_SX_SY: begin
              // Numerator as sign and magnitude.
              if (sa != sb) begin
                mag_nxt = MW'(ta_r) + MW'(prod_lo);
                neg_nxt = sa;
              end else if (ta_r >= prod_lo) begin
                mag_nxt = MW'(ta_r - prod_lo);
                neg_nxt = (ta_r != prod_lo) && sa;
              end else begin
                mag_nxt = MW'(prod_lo - ta_r);
                neg_nxt = !sa;
              end
              if (vx_r == '0 || vy_r == '0) begin
                zvar_nxt  = 1'b1;
                q_nxt     = '0;
                state_nxt = ST_DONE;
              end
            end
            OP_VX_VY: begin
              d2_nxt = SW'(mul_rsp.prod[DW-1:0]) << SEARCH_SHIFT;
            end
            default: begin
              e_nxt     = SW'(mul_rsp.prod) << SEARCH_SHIFT;
              dq_nxt    = '0;
              q_nxt     = '0;
              k_nxt     = K_W'(Q_W - 1);
              state_nxt = ST_DELTA;
            end
          endcase
        end
      end

      ST_DELTA: begin
        delta_nxt = dq_r + d2_r;
        state_nxt = ST_TEST;
      end

      ST_TEST: begin
        // Keep the trial bit when the square still fits under the remainder and the top bit of q is clear.
        if (take) begin
          e_nxt  = diff[SW-1:0];
          q_nxt  = q_r | (Q_W'(1) << k_r);
          dq_nxt = dq_sum[SW:1];
        end else begin
          dq_nxt = dq_r >> 1;
        end
        d2_nxt = d2_r >> 2;
        if (k_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          k_nxt     = k_r - K_W'(1);
          state_nxt = ST_DELTA;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          if (zvar_r) begin
            corr_nxt = '0;
          end else if (neg_r) begin
            corr_nxt = ~q_r + Q_W'(1);
          end else begin
            corr_nxt = q_r[Q_W-1] ? CORR_MAX : q_r;
          end
          if (job_r.overflow) begin
            status_nxt = STAT_CAPACITY;
          end else if (zvar_r) begin
            status_nxt = STAT_ZERO_VAR;
          end else begin
            status_nxt = STAT_OK;
          end
          pcount_nxt    = OUT_CNT_W'(job_r.count);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    job_r    <= job_nxt;
    ta_r     <= ta_nxt;
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    zvar_r   <= zvar_nxt;
    e_r      <= e_nxt;
    dq_r     <= dq_nxt;
    d2_r     <= d2_nxt;
    delta_r  <= delta_nxt;
    q_r      <= q_nxt;
    k_r      <= k_nxt;
    corr_r   <= corr_nxt;
    status_r <= status_nxt;
    pcount_r <= pcount_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_correlation = corr_r;
  assign out_status      = status_r;
  assign out_pair_count  = pcount_r;

endmodule

FILE: sv/pearson_correlation_unit.sv
// Pearson correlation of a stream of paired signed samples. The front end takes one
// (x, y) word per clock unless stalled and accumulates the count, sums, sums of squares
// and cross sum; the word marked last_pair closes the set and its totals move into a
// two-entry queue. The back end then forms r = (n*Sxy - Sx*Sy) / sqrt(Vx*Vy) exactly,
// as sign * floor(32768*|r|) with +1 held at 32767, on one iterative multiplier that
// forms eight products in turn, followed by a sixteen-step bit search; a set with zero
// variance ends after six products, without the search. The front end keeps accepting
// words while the back end works; it stalls only when two closed sets are waiting for
// the back end or on their way to the queue. A finished result sits in an output
// register, so the back end can start the next set while it waits to be taken. Status
// is 1 for zero variance (correlation 0) and 2 when pairs beyond the capacity were
// dropped.
module pearson_correlation_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pcorr_pkg::IN_W-1:0]    in_sample_x,
  input  logic signed [pcorr_pkg::IN_W-1:0]    in_sample_y,
  input  logic                                 in_last_pair,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pcorr_pkg::CORR_W-1:0]  out_correlation,
  output logic [pcorr_pkg::STAT_W-1:0]         out_status,
  output logic [pcorr_pkg::OUT_CNT_W-1:0]      out_pair_count
);
  import pcorr_pkg::*;

  logic             push;
  snap_t            push_data;
  logic             pop;
  snap_t            head;
  logic [LVL_W-1:0] level;
  mul_req_t         mul_req;
  mul_rsp_t         mul_rsp;

  // Accumulating front end.
  pcorr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_x  (in_sample_x),
    .in_sample_y  (in_sample_y),
    .in_last_pair (in_last_pair),
    .q_level      (level),
    .push         (push),
    .push_data    (push_data)
  );

  // Closed sets waiting for the back end.
  pcorr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .level     (level)
  );

  // Multiplier shared by the back end's multiply steps.
  pcorr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // Ratio and root back end.
  pcorr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_level         (level),
    .q_head          (head),
    .q_pop           (pop),
    .mul_req         (mul_req),
    .mul_rsp         (mul_rsp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_correlation (out_correlation),
    .out_status      (out_status),
    .out_pair_count  (out_pair_count)
  );

endmodule
